[src/dbd_pkg.sv]
package dbd_pkg;

  localparam int unsigned DAY_W   = 6;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned COUNT_W = 22;
  localparam int unsigned ORD_W   = 23;
  localparam int unsigned DBM_W   = 9;
  localparam int unsigned CENT_W  = 8;

  localparam int unsigned MAX_YEAR = 10000;

  // floor(n / 100) = (n * DIV100_MUL) >> DIV100_SHIFT for every 14-bit n.
  localparam int unsigned DIV100_SHIFT = 20;
  localparam int unsigned DIV100_MUL   = 10486;
  localparam int unsigned PROD_W       = 2 * YEAR_W;

  localparam logic [MONTH_W-1:0] FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] DEC = MONTH_W'(12);

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_START_BAD = 2'd1,
    ST_END_BAD   = 2'd2,
    ST_ORDER     = 2'd3
  } dbd_status_t;

  // Stage advance strobes shared by both date units.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } dbd_adv_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
      4'd4, 4'd6, 4'd9, 4'd11:                    len = DAY_W'(30);
      4'd2:                                       len = DAY_W'(28);
      default:                                    len = '0;
    endcase
    return len;
  endfunction

  function automatic logic [DBM_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
    logic [DBM_W-1:0] dbm;
    case (m)
      4'd2:    dbm = DBM_W'(31);
      4'd3:    dbm = DBM_W'(59);
      4'd4:    dbm = DBM_W'(90);
      4'd5:    dbm = DBM_W'(120);
      4'd6:    dbm = DBM_W'(151);
      4'd7:    dbm = DBM_W'(181);
      4'd8:    dbm = DBM_W'(212);
      4'd9:    dbm = DBM_W'(243);
      4'd10:   dbm = DBM_W'(273);
      4'd11:   dbm = DBM_W'(304);
      4'd12:   dbm = DBM_W'(334);
      default: dbm = '0;
    endcase
    return dbm;
  endfunction

endpackage

[src/dbd_ordinal.sv]
module dbd_ordinal
  import dbd_pkg::*;
(
  input  logic               clk,
  input  dbd_adv_t           adv,
  input  logic [DAY_W-1:0]   day,
  input  logic [MONTH_W-1:0] month,
  input  logic [YEAR_W-1:0]  year,
  output logic [ORD_W-1:0]   ordinal,
  output logic               ok
);

  // Stage 1: validity without the leap rule, and the century reciprocal product.
  logic [YEAR_W-1:0]  n_in;
  logic [DAY_W-1:0]   lim;
  logic               base_ok;

  logic [YEAR_W-1:0]  s1_n;
  logic [PROD_W-1:0]  s1_prod;
  logic               s1_ok;
  logic               s1_feb29;
  logic               s1_after_feb;
  logic [DAY_W-1:0]   s1_day;
  logic [DBM_W-1:0]   s1_dbm;
  logic [1:0]         s1_ylo;

  assign n_in = year - YEAR_W'(1);
  assign lim  = (month == FEB) ? DAY_W'(29) : month_len(month);
  assign base_ok = (day != '0) && (month != '0) && (month <= DEC) && (year != '0) &&
                   (year <= YEAR_W'(MAX_YEAR)) && (day <= lim);

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      s1_n         <= n_in;
      s1_prod      <= PROD_W'(n_in) * PROD_W'(DIV100_MUL);
      s1_ok        <= base_ok;
      s1_feb29     <= (month == FEB) && (day == DAY_W'(29));
      s1_after_feb <= (month > FEB);
      s1_day       <= day;
      s1_dbm       <= days_before_month(month);
      s1_ylo       <= year[1:0];
    end
  end

  // Stage 2: centuries, the remainder test and the whole-year days.
  logic [CENT_W-1:0]  cent;
  logic [YEAR_W-1:0]  rem100;

  logic [YEAR_W-1:0]  s2_n;
  logic [CENT_W-1:0]  s2_cent;
  logic               s2_r99;
  logic [ORD_W-1:0]   s2_n365;
  logic               s2_ok;
  logic               s2_feb29;
  logic               s2_after_feb;
  logic [DAY_W-1:0]   s2_day;
  logic [DBM_W-1:0]   s2_dbm;
  logic [1:0]         s2_ylo;

  assign cent   = s1_prod[DIV100_SHIFT +: CENT_W];
  assign rem100 = s1_n - YEAR_W'(cent) * YEAR_W'(100);

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      s2_n         <= s1_n;
      s2_cent      <= cent;
      // n = year - 1, so the year is a whole century when n leaves 99.
      s2_r99       <= (rem100 == YEAR_W'(99));
      s2_n365      <= ORD_W'(s1_n) * ORD_W'(365);
      s2_ok        <= s1_ok;
      s2_feb29     <= s1_feb29;
      s2_after_feb <= s1_after_feb;
      s2_day       <= s1_day;
      s2_dbm       <= s1_dbm;
      s2_ylo       <= s1_ylo;
    end
  end

  // Stage 3: leap rule and the ordinal sum.
  logic               leap;
  logic [ORD_W-1:0]   ord_sum;

  // For a century year, year / 100 is cent + 1, so it is a multiple of four
  // exactly when the low bits of cent are both set.
  assign leap = (s2_ylo == 2'b00) && (!s2_r99 || (s2_cent[1:0] == 2'b11));

  assign ord_sum = s2_n365 + ORD_W'(s2_n >> 2) - ORD_W'(s2_cent) + ORD_W'(s2_cent >> 2) +
                   ORD_W'(s2_dbm) + ORD_W'(s2_day) + ORD_W'(s2_after_feb && leap);

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      ordinal <= ord_sum;
      ok      <= s2_ok && (!s2_feb29 || leap);
    end
  end

endmodule

[src/days_between_dates.sv]
// Days between two Gregorian dates. Each word carries a start and an end date;
// the result word carries the day count and a status (ok, start invalid, end
// invalid, end before start), with a zero count whenever the status is not ok.
// A new word is taken every cycle while in_ready is high. Its result is built up in registered steps:
// three stages turn each date into an ordinal day number (the century division
// is a reciprocal multiply followed by a remainder test) and the output
// register holds the compare and subtract. A stalled output holds the pipeline
// back only as far as its bubbles are used up.
module days_between_dates
  import dbd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [DAY_W-1:0]   start_day,
  input  logic [MONTH_W-1:0] start_month,
  input  logic [YEAR_W-1:0]  start_year,
  input  logic [DAY_W-1:0]   end_day,
  input  logic [MONTH_W-1:0] end_month,
  input  logic [YEAR_W-1:0]  end_year,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [COUNT_W-1:0] day_count,
  output logic [1:0]         status
);

  logic       v1, v2, v3;
  logic       free4;
  dbd_adv_t   adv;

  // A stage may load when it is empty or its word moves on in this cycle.
  assign free4   = !out_valid || out_ready;
  assign adv.s3  = !v3 || free4;
  assign adv.s2  = !v2 || adv.s3;
  assign adv.s1  = !v1 || adv.s2;
  assign in_ready = adv.s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv.s1) v1 <= in_valid;
      if (adv.s2) v2 <= v1;
      if (adv.s3) v3 <= v2;
      if (free4)  out_valid <= v3;
    end
  end

  logic [ORD_W-1:0] start_ord, end_ord;
  logic             start_ok, end_ok;

  dbd_ordinal u_start (
    .clk     (clk),
    .adv     (adv),
    .day     (start_day),
    .month   (start_month),
    .year    (start_year),
    .ordinal (start_ord),
    .ok      (start_ok)
  );

  dbd_ordinal u_end (
    .clk     (clk),
    .adv     (adv),
    .day     (end_day),
    .month   (end_month),
    .year    (end_year),
    .ordinal (end_ord),
    .ok      (end_ok)
  );

  logic [ORD_W-1:0] diff;
  dbd_status_t      st_next;

  assign diff = end_ord - start_ord;

  always_comb begin
    if (!start_ok) begin
      st_next = ST_START_BAD;
    end else if (!end_ok) begin
      st_next = ST_END_BAD;
    end else if (end_ord < start_ord) begin
      st_next = ST_ORDER;
    end else begin
      st_next = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (free4) begin
      status    <= st_next;
      day_count <= (st_next == ST_OK) ? diff[COUNT_W-1:0] : '0;
    end
  end

  a_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> day_count == '0)
    else $error("nonzero day count with an error status");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while the output register is empty");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid && !v1 && !v2 && !v3)
    else $error("pipeline not empty after reset");

  a_stage3_holds: assert property (@(posedge clk) disable iff (rst)
    v3 && !free4 |=> v3 && $stable(start_ord) && $stable(end_ord))
    else $error("last date stage lost its word during a stall");

endmodule
